FILE: rtl/ps2s2_pkg.sv
`timescale 1ns / 1ps

package ps2s2_pkg;

  // Translation covers codes below this bound only (bound values above 128 have no effect)
  localparam int unsigned MAP_ENTRIES = 128;

  // Prefix bytes
  localparam logic [7:0] CODE_EXT = 8'hE0;
  localparam logic [7:0] CODE_REL = 8'hF0;

  // Modifier and special keys
  localparam logic [7:0] KEY_LSHIFT = 8'h12;
  localparam logic [7:0] KEY_RSHIFT = 8'h59;
  localparam logic [7:0] KEY_CTRL   = 8'h14;
  localparam logic [7:0] KEY_ALT    = 8'h11;
  localparam logic [7:0] KEY_CAPS   = 8'h58;

  // Extended arrow keys
  localparam logic [7:0] KEY_UP    = 8'h75;
  localparam logic [7:0] KEY_DOWN  = 8'h72;
  localparam logic [7:0] KEY_LEFT  = 8'h6B;
  localparam logic [7:0] KEY_RIGHT = 8'h74;

  localparam logic [6:0] CHR_NONE  = 7'd0;
  localparam logic [6:0] CHR_UP    = 7'd1;
  localparam logic [6:0] CHR_DOWN  = 7'd2;
  localparam logic [6:0] CHR_LEFT  = 7'd3;
  localparam logic [6:0] CHR_RIGHT = 7'd4;

  // Modifier flag bit positions
  localparam int unsigned MF_LSHIFT = 0;
  localparam int unsigned MF_RSHIFT = 1;
  localparam int unsigned MF_LCTRL  = 2;
  localparam int unsigned MF_RCTRL  = 3;
  localparam int unsigned MF_LALT   = 4;
  localparam int unsigned MF_RALT   = 5;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    ITEM_SKIP = 1'b0,  // aux or prefix byte: status only
    ITEM_KEY  = 1'b1   // key event candidate
  } item_kind_e;

  // Classified request passed from front to back
  typedef struct packed {
    item_kind_e kind;
    logic       ext;
    logic       brk;
    logic [7:0] code;
  } key_item_t;

  typedef struct packed {
    logic [6:0] plain;
    logic [6:0] upper;
    logic       alpha;
  } xlat_t;

  // Set 2 translation table; modifier keys and empty slots give zero
  function automatic xlat_t xlat_lookup(input logic [6:0] code);
    xlat_t x;
    x = '{7'h00, 7'h00, 1'b0};
    unique case (code)
      7'h0D: x = '{7'h09, 7'h09, 1'b0};
      7'h0E: x = '{7'h60, 7'h7E, 1'b0};
      7'h15: x = '{7'h71, 7'h51, 1'b1};
      7'h16: x = '{7'h31, 7'h21, 1'b0};
      7'h1A: x = '{7'h7A, 7'h5A, 1'b1};
      7'h1B: x = '{7'h73, 7'h53, 1'b1};
      7'h1C: x = '{7'h61, 7'h41, 1'b1};
      7'h1D: x = '{7'h77, 7'h57, 1'b1};
      7'h1E: x = '{7'h32, 7'h40, 1'b0};
      7'h21: x = '{7'h63, 7'h43, 1'b1};
      7'h22: x = '{7'h78, 7'h58, 1'b1};
      7'h23: x = '{7'h64, 7'h44, 1'b1};
      7'h24: x = '{7'h65, 7'h45, 1'b1};
      7'h25: x = '{7'h34, 7'h24, 1'b0};
      7'h26: x = '{7'h33, 7'h23, 1'b0};
      7'h29: x = '{7'h20, 7'h20, 1'b0};
      7'h2A: x = '{7'h76, 7'h56, 1'b1};
      7'h2B: x = '{7'h66, 7'h46, 1'b1};
      7'h2C: x = '{7'h74, 7'h54, 1'b1};
      7'h2D: x = '{7'h72, 7'h52, 1'b1};
      7'h2E: x = '{7'h35, 7'h25, 1'b0};
      7'h31: x = '{7'h6E, 7'h4E, 1'b1};
      7'h32: x = '{7'h62, 7'h42, 1'b1};
      7'h33: x = '{7'h68, 7'h48, 1'b1};
      7'h34: x = '{7'h67, 7'h47, 1'b1};
      7'h35: x = '{7'h79, 7'h59, 1'b1};
      7'h36: x = '{7'h36, 7'h5E, 1'b0};
      7'h3A: x = '{7'h6D, 7'h4D, 1'b1};
      7'h3B: x = '{7'h6A, 7'h4A, 1'b1};
      7'h3C: x = '{7'h75, 7'h55, 1'b1};
      7'h3D: x = '{7'h37, 7'h26, 1'b0};
      7'h3E: x = '{7'h38, 7'h2A, 1'b0};
      7'h41: x = '{7'h2C, 7'h3C, 1'b0};
      7'h42: x = '{7'h6B, 7'h4B, 1'b1};
      7'h43: x = '{7'h69, 7'h49, 1'b1};
      7'h44: x = '{7'h6F, 7'h4F, 1'b1};
      7'h45: x = '{7'h30, 7'h29, 1'b0};
      7'h46: x = '{7'h39, 7'h28, 1'b0};
      7'h49: x = '{7'h2E, 7'h3E, 1'b0};
      7'h4A: x = '{7'h2F, 7'h3F, 1'b0};
      7'h4B: x = '{7'h6C, 7'h4C, 1'b1};
      7'h4C: x = '{7'h3B, 7'h3A, 1'b0};
      7'h4D: x = '{7'h70, 7'h50, 1'b1};
      7'h4E: x = '{7'h2D, 7'h5F, 1'b0};
      7'h52: x = '{7'h27, 7'h22, 1'b0};
      7'h54: x = '{7'h5B, 7'h7B, 1'b0};
      7'h55: x = '{7'h3D, 7'h2B, 1'b0};
      7'h5A: x = '{7'h0A, 7'h0A, 1'b0};
      7'h5B: x = '{7'h5D, 7'h7D, 1'b0};
      7'h5D: x = '{7'h5C, 7'h7C, 1'b0};
      7'h66: x = '{7'h08, 7'h08, 1'b0};
      7'h76: x = '{7'h1B, 7'h1B, 1'b0};
      default: x = '{7'h00, 7'h00, 1'b0};
    endcase
    return x;
  endfunction

endpackage

FILE: rtl/ps2s2_front.sv
`timescale 1ns / 1ps

module ps2s2_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   from_aux_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output ps2s2_pkg::key_item_t   item_o
);

  logic ext_pend_q, ext_pend_d;
  logic rel_pend_q, rel_pend_d;
  logic is_ext, is_rel;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign is_ext = (data_byte_i == ps2s2_pkg::CODE_EXT);
  assign is_rel = (data_byte_i == ps2s2_pkg::CODE_REL);

  // Classify the byte and fold in pending prefixes
  always_comb begin
    ext_pend_d  = ext_pend_q;
    rel_pend_d  = rel_pend_q;
    item_o.kind = ps2s2_pkg::ITEM_SKIP;
    item_o.ext  = ext_pend_q;
    item_o.brk  = rel_pend_q;
    item_o.code = data_byte_i;
    if (push_o && !from_aux_i) begin
      priority if (is_ext) begin
        ext_pend_d = 1'b1;
      end else if (is_rel) begin
        rel_pend_d = 1'b1;
      end else begin
        item_o.kind = ps2s2_pkg::ITEM_KEY;
        ext_pend_d  = 1'b0;
        rel_pend_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_pend_q <= 1'b0;
      rel_pend_q <= 1'b0;
    end else begin
      ext_pend_q <= ext_pend_d;
      rel_pend_q <= rel_pend_d;
    end
  end

endmodule

FILE: rtl/ps2s2_queue.sv
`timescale 1ns / 1ps

module ps2s2_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ps2s2_pkg::key_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output ps2s2_pkg::key_item_t item_o
);

  localparam int unsigned PtrW = $clog2(ps2s2_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(ps2s2_pkg::QUEUE_DEPTH + 1);

  ps2s2_pkg::key_item_t mem_q [ps2s2_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(ps2s2_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(ps2s2_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(ps2s2_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/ps2s2_back.sv
`timescale 1ns / 1ps

module ps2s2_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  ps2s2_pkg::key_item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 ascii_valid_o,
  output logic [6:0]           ascii_code_o,
  output logic                 event_valid_o,
  output logic                 event_pressed_o,
  output logic                 event_extended_o,
  output logic [7:0]           event_code_o,
  output logic                 shift_held_o,
  output logic                 ctrl_active_o,
  output logic                 alt_active_o,
  output logic                 caps_on_o
);

  logic [255:0] down_q, down_d;
  logic [5:0]   mods_q, mods_d;
  logic         caps_q, caps_d;

  logic         out_valid_q, out_valid_d;
  logic         asc_vld_q, ev_vld_q, ev_make_q, ev_ext_q;
  logic [6:0]   asc_q;
  logic [7:0]   ev_code_q;
  logic         shift_q, ctrl_q, alt_q, caps_out_q;

  logic         ev, ev_make, ev_ext;
  logic [6:0]   ch;
  logic         shift_nxt;
  logic         in_range;
  ps2s2_pkg::xlat_t xe;

  assign pop_o = item_valid_i && (!out_valid_q || out_ready_i);

  assign in_range = (item_i.code[7] == 1'b0) &&
                    ({1'b0, item_i.code} < 9'(ps2s2_pkg::MAP_ENTRIES));
  assign xe       = ps2s2_pkg::xlat_lookup(item_i.code[6:0]);
  assign shift_nxt = mods_d[ps2s2_pkg::MF_LSHIFT] || mods_d[ps2s2_pkg::MF_RSHIFT];

  // Key event processing: pressed map, modifiers, translation
  always_comb begin
    down_d  = down_q;
    mods_d  = mods_q;
    caps_d  = caps_q;
    ev      = 1'b0;
    ev_make = 1'b0;
    ev_ext  = 1'b0;
    ch      = ps2s2_pkg::CHR_NONE;
    if (pop_o && item_i.kind == ps2s2_pkg::ITEM_KEY) begin
      // a repeated plain make falls through with no event
      if (item_i.brk || item_i.ext || !down_q[item_i.code]) begin
        ev      = 1'b1;
        ev_make = !item_i.brk;
        ev_ext  = item_i.ext;
        // pressed map ignores extended keys
        if (!item_i.ext) begin
          down_d[item_i.code] = !item_i.brk;
        end
        // modifier tracking
        if (item_i.ext) begin
          if (item_i.code == ps2s2_pkg::KEY_CTRL) begin
            mods_d[ps2s2_pkg::MF_RCTRL] = !item_i.brk;
          end else if (item_i.code == ps2s2_pkg::KEY_ALT) begin
            mods_d[ps2s2_pkg::MF_RALT] = !item_i.brk;
          end
        end else begin
          if (item_i.code == ps2s2_pkg::KEY_LSHIFT) begin
            mods_d[ps2s2_pkg::MF_LSHIFT] = !item_i.brk;
          end
          if (item_i.code == ps2s2_pkg::KEY_RSHIFT) begin
            mods_d[ps2s2_pkg::MF_RSHIFT] = !item_i.brk;
          end
          if (item_i.code == ps2s2_pkg::KEY_CTRL) begin
            mods_d[ps2s2_pkg::MF_LCTRL] = !item_i.brk;
          end
          if (item_i.code == ps2s2_pkg::KEY_ALT) begin
            mods_d[ps2s2_pkg::MF_LALT] = !item_i.brk;
          end
          if (item_i.code == ps2s2_pkg::KEY_CAPS && !item_i.brk) begin
            caps_d = !caps_q;
          end
        end
      end
      // character for makes
      if (ev && ev_make) begin
        if (item_i.ext) begin
          if (item_i.code == ps2s2_pkg::KEY_UP) begin
            ch = ps2s2_pkg::CHR_UP;
          end else if (item_i.code == ps2s2_pkg::KEY_DOWN) begin
            ch = ps2s2_pkg::CHR_DOWN;
          end else if (item_i.code == ps2s2_pkg::KEY_LEFT) begin
            ch = ps2s2_pkg::CHR_LEFT;
          end else if (item_i.code == ps2s2_pkg::KEY_RIGHT) begin
            ch = ps2s2_pkg::CHR_RIGHT;
          end
        end else if (in_range) begin
          if (xe.alpha) begin
            ch = (shift_nxt != caps_d) ? xe.upper : xe.plain;
          end else begin
            ch = shift_nxt ? xe.upper : xe.plain;
          end
        end
      end
    end
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q      <= '0;
      mods_q      <= '0;
      caps_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      down_q      <= down_d;
      mods_q      <= mods_d;
      caps_q      <= caps_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      asc_vld_q  <= (ch != ps2s2_pkg::CHR_NONE);
      asc_q      <= ch;
      ev_vld_q   <= ev;
      ev_make_q  <= ev_make;
      ev_ext_q   <= ev_ext;
      ev_code_q  <= ev ? item_i.code : 8'h00;
      shift_q    <= shift_nxt;
      ctrl_q     <= mods_d[ps2s2_pkg::MF_LCTRL] || mods_d[ps2s2_pkg::MF_RCTRL];
      alt_q      <= mods_d[ps2s2_pkg::MF_LALT] || mods_d[ps2s2_pkg::MF_RALT];
      caps_out_q <= caps_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ascii_valid_o    = asc_vld_q;
  assign ascii_code_o     = asc_q;
  assign event_valid_o    = ev_vld_q;
  assign event_pressed_o  = ev_make_q;
  assign event_extended_o = ev_ext_q;
  assign event_code_o     = ev_code_q;
  assign shift_held_o     = shift_q;
  assign ctrl_active_o    = ctrl_q;
  assign alt_active_o     = alt_q;
  assign caps_on_o        = caps_out_q;

endmodule

FILE: rtl/ps2_set2_scancode_decoder.sv
`timescale 1ns / 1ps

// Channel  | Handshake               | Payload
// ---------+-------------------------+---------------------------------------------
// input    | in_valid_i / in_ready_o | data_byte_i, from_aux_i
// output   | out_valid_o/out_ready_i | ascii_*, event_*, shift/ctrl/alt, caps_on
//
// One byte per cycle sustained while the output is taken; every byte gives exactly one result.
// Each request passes through the two-entry queue, then the back end's output register.
// Reset clears the prefix flags, modifier and caps state and the 256-bit
// pressed map at once; no clearing pass is needed.
// A stalled output fills the queue, after which in_ready_o drops.

module ps2_set2_scancode_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       from_aux_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       ascii_valid_o,
  output logic [6:0] ascii_code_o,
  output logic       event_valid_o,
  output logic       event_pressed_o,
  output logic       event_extended_o,
  output logic [7:0] event_code_o,
  output logic       shift_held_o,
  output logic       ctrl_active_o,
  output logic       alt_active_o,
  output logic       caps_on_o
);

  ps2s2_pkg::key_item_t push_item, head_item;
  logic push, q_full, head_valid, pop;

  // Front: prefix tracking and classification
  ps2s2_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .from_aux_i  (from_aux_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  // Decoupling queue
  ps2s2_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  // Back: key state, translation, output register
  ps2s2_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (head_valid),
    .item_i           (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ascii_valid_o    (ascii_valid_o),
    .ascii_code_o     (ascii_code_o),
    .event_valid_o    (event_valid_o),
    .event_pressed_o  (event_pressed_o),
    .event_extended_o (event_extended_o),
    .event_code_o     (event_code_o),
    .shift_held_o     (shift_held_o),
    .ctrl_active_o    (ctrl_active_o),
    .alt_active_o     (alt_active_o),
    .caps_on_o        (caps_on_o)
  );

  // A character always comes with a non-zero code and a key make
  a_ascii_make: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ascii_valid_o |-> ascii_code_o != 7'd0 && event_valid_o && event_pressed_o)
    else $error("character without a key make");

  // No event means a cleared event code and flags
  a_event_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !event_valid_o |->
      event_code_o == 8'h00 && !event_pressed_o && !event_extended_o && !ascii_valid_o)
    else $error("event fields set without an event");

  // An extended make only ever gives an arrow code
  a_ext_arrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ascii_valid_o && event_extended_o |-> ascii_code_o <= 7'd4)
    else $error("extended make gave a non-arrow character");

endmodule

FILE: tb/tb_ps2_set2_scancode_decoder.sv
`timescale 1ns / 1ps

module tb_ps2_set2_scancode_decoder;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned KEY_BYTES   = 700;  // non-aux requests to feed at the least
  localparam int unsigned HOLD_AFTER  = 150;  // results taken before the long stall
  localparam int unsigned HOLD_CYCLES = 80;

  // One decoded result, field for field as on the output ports
  typedef struct packed {
    logic       ascii_valid;
    logic [6:0] ascii_code;
    logic       event_valid;
    logic       event_pressed;
    logic       event_extended;
    logic [7:0] event_code;
    logic       shift;
    logic       ctrl;
    logic       alt;
    logic       caps;
  } key_result_t;

  // Directed request; the result is written out where it is obvious
  typedef struct packed {
    logic [7:0]  code;
    logic        aux;
    logic        fixed;
    key_result_t want;
  } stim_row_t;

  localparam key_result_t IDLE = '0;

  localparam stim_row_t DIRECTED [24] = '{
    // auxiliary bytes are ignored, a prefix among them too
    '{8'hFF, 1'b1, 1'b1, IDLE},
    '{8'h00, 1'b1, 1'b1, IDLE},
    '{ps2s2_pkg::CODE_EXT, 1'b1, 1'b1, IDLE},
    // extended make of an arrow
    '{ps2s2_pkg::CODE_EXT, 1'b0, 1'b1, IDLE},
    '{ps2s2_pkg::KEY_UP, 1'b0, 1'b1,
      '{1'b1, ps2s2_pkg::CHR_UP, 1'b1, 1'b1, 1'b1, ps2s2_pkg::KEY_UP,
        1'b0, 1'b0, 1'b0, 1'b0}},
    // extended break, both prefix orders
    '{ps2s2_pkg::CODE_EXT, 1'b0, 1'b1, IDLE},
    '{ps2s2_pkg::CODE_REL, 1'b0, 1'b1, IDLE},
    '{ps2s2_pkg::KEY_UP, 1'b0, 1'b1,
      '{1'b0, ps2s2_pkg::CHR_NONE, 1'b1, 1'b0, 1'b1, ps2s2_pkg::KEY_UP,
        1'b0, 1'b0, 1'b0, 1'b0}},
    '{ps2s2_pkg::CODE_REL, 1'b0, 1'b1, IDLE},
    '{ps2s2_pkg::CODE_EXT, 1'b0, 1'b1, IDLE},
    '{ps2s2_pkg::KEY_LEFT, 1'b0, 1'b1,
      '{1'b0, ps2s2_pkg::CHR_NONE, 1'b1, 1'b0, 1'b1, ps2s2_pkg::KEY_LEFT,
        1'b0, 1'b0, 1'b0, 1'b0}},
    // plain make, then a repeat of it
    '{8'h1C, 1'b0, 1'b0, IDLE},
    '{8'h1C, 1'b0, 1'b1, IDLE},
    // shift and caps lock rules
    '{ps2s2_pkg::KEY_LSHIFT, 1'b0, 1'b0, IDLE},
    '{8'h15, 1'b0, 1'b0, IDLE},
    '{ps2s2_pkg::KEY_CAPS, 1'b0, 1'b0, IDLE},
    '{8'h2A, 1'b0, 1'b0, IDLE},
    '{8'h16, 1'b0, 1'b0, IDLE},
    // codes with no character
    '{8'hFF, 1'b0, 1'b0, IDLE},
    '{8'h00, 1'b0, 1'b0, IDLE},
    // right ctrl and right alt
    '{ps2s2_pkg::CODE_EXT, 1'b0, 1'b0, IDLE},
    '{ps2s2_pkg::KEY_CTRL, 1'b0, 1'b0, IDLE},
    '{ps2s2_pkg::CODE_EXT, 1'b0, 1'b0, IDLE},
    '{ps2s2_pkg::KEY_ALT, 1'b0, 1'b0, IDLE}
  };

  localparam logic [7:0] TYPING_KEYS [18] = '{
    8'h1C, 8'h1B, 8'h23, 8'h15, 8'h1A, 8'h2A, 8'h16, 8'h1E, 8'h29,
    8'h5A, 8'h66, 8'h0D, 8'h0E, 8'h52, 8'h5D, 8'h4A, 8'h76, 8'h44
  };
  localparam logic [7:0] MOD_KEYS [5] = '{
    ps2s2_pkg::KEY_LSHIFT, ps2s2_pkg::KEY_RSHIFT, ps2s2_pkg::KEY_CTRL,
    ps2s2_pkg::KEY_ALT, ps2s2_pkg::KEY_CAPS
  };
  localparam logic [7:0] EXT_KEYS [6] = '{
    ps2s2_pkg::KEY_UP, ps2s2_pkg::KEY_DOWN, ps2s2_pkg::KEY_LEFT,
    ps2s2_pkg::KEY_RIGHT, ps2s2_pkg::KEY_CTRL, ps2s2_pkg::KEY_ALT
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = '0;
  logic       from_aux = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       ascii_valid;
  logic [6:0] ascii_code;
  logic       event_valid;
  logic       event_pressed;
  logic       event_extended;
  logic [7:0] event_code;
  logic       shift_held;
  logic       ctrl_active;
  logic       alt_active;
  logic       caps_on;

  // Keyboard state as the decoder should hold it
  logic       ext_pend = 1'b0;
  logic       rel_pend = 1'b0;
  bit         key_down [256];
  logic [5:0] mods = '0;
  logic       caps = 1'b0;

  key_result_t expected_keys [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned key_bytes_fed = 0;
  int          send_run = 0;
  bit          send_quiet = 1'b0;

  ps2_set2_scancode_decoder dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_byte_i      (data_byte),
    .from_aux_i       (from_aux),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .ascii_valid_o    (ascii_valid),
    .ascii_code_o     (ascii_code),
    .event_valid_o    (event_valid),
    .event_pressed_o  (event_pressed),
    .event_extended_o (event_extended),
    .event_code_o     (event_code),
    .shift_held_o     (shift_held),
    .ctrl_active_o    (ctrl_active),
    .alt_active_o     (alt_active),
    .caps_on_o        (caps_on)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= 100) $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Wait before the next request or result; runs of zero waits now and then
  task automatic pick_wait(inout int run, inout bit quiet, output int n);
    if (run == 0) begin
      quiet = ($urandom_range(0, 3) == 0);
      run = $urandom_range(10, 40);
    end
    run--;
    n = quiet ? 0 : $urandom_range(0, 7);
  endtask

  // Shift, ctrl and alt flags, caps toggle
  function automatic void track_mods(input logic [7:0] code, input logic make,
                                     input logic ext);
    if (ext) begin
      if (code == ps2s2_pkg::KEY_CTRL) mods[ps2s2_pkg::MF_RCTRL] = make;
      else if (code == ps2s2_pkg::KEY_ALT) mods[ps2s2_pkg::MF_RALT] = make;
    end else begin
      case (code)
        ps2s2_pkg::KEY_LSHIFT: mods[ps2s2_pkg::MF_LSHIFT] = make;
        ps2s2_pkg::KEY_RSHIFT: mods[ps2s2_pkg::MF_RSHIFT] = make;
        ps2s2_pkg::KEY_CTRL:   mods[ps2s2_pkg::MF_LCTRL] = make;
        ps2s2_pkg::KEY_ALT:    mods[ps2s2_pkg::MF_LALT] = make;
        ps2s2_pkg::KEY_CAPS:   if (make) caps = ~caps;
        default:               ;
      endcase
    end
  endfunction

  // Expected result of one byte; advances the predicted keyboard state
  function automatic key_result_t decode_byte(input logic [7:0] code, input logic aux);
    key_result_t r;
    logic        ext;
    logic        brk;
    logic [15:0] glyph;
    logic        alpha;
    logic        up;
    r = '0;
    if (!aux) begin
      if (code == ps2s2_pkg::CODE_EXT) begin
        ext_pend = 1'b1;
      end else if (code == ps2s2_pkg::CODE_REL) begin
        rel_pend = 1'b1;
      end else begin
        ext = ext_pend;
        brk = rel_pend;
        ext_pend = 1'b0;
        rel_pend = 1'b0;
        if (brk) begin
          // extended breaks leave the pressed map alone
          if (!ext) key_down[code] = 1'b0;
          track_mods(code, 1'b0, ext);
          r.event_valid = 1'b1;
          r.event_extended = ext;
          r.event_code = code;
        end else if (ext) begin
          track_mods(code, 1'b1, 1'b1);
          r.event_valid = 1'b1;
          r.event_pressed = 1'b1;
          r.event_extended = 1'b1;
          r.event_code = code;
          case (code)
            ps2s2_pkg::KEY_UP:    r.ascii_code = ps2s2_pkg::CHR_UP;
            ps2s2_pkg::KEY_DOWN:  r.ascii_code = ps2s2_pkg::CHR_DOWN;
            ps2s2_pkg::KEY_LEFT:  r.ascii_code = ps2s2_pkg::CHR_LEFT;
            ps2s2_pkg::KEY_RIGHT: r.ascii_code = ps2s2_pkg::CHR_RIGHT;
            default:              r.ascii_code = ps2s2_pkg::CHR_NONE;
          endcase
          r.ascii_valid = (r.ascii_code != ps2s2_pkg::CHR_NONE);
        end else if (!key_down[code]) begin
          key_down[code] = 1'b1;
          track_mods(code, 1'b1, 1'b0);
          r.event_valid = 1'b1;
          r.event_pressed = 1'b1;
          r.event_code = code;
          // {plain, shifted}; modifiers and empty slots stay zero
          glyph = 16'h0000;
          if (code < ps2s2_pkg::MAP_ENTRIES) begin
            case (code)
              8'h0D: glyph = 16'h0909;
              8'h0E: glyph = 16'h607E;
              8'h15: glyph = "qQ";
              8'h16: glyph = "1!";
              8'h1A: glyph = "zZ";
              8'h1B: glyph = "sS";
              8'h1C: glyph = "aA";
              8'h1D: glyph = "wW";
              8'h1E: glyph = "2@";
              8'h21: glyph = "cC";
              8'h22: glyph = "xX";
              8'h23: glyph = "dD";
              8'h24: glyph = "eE";
              8'h25: glyph = "4$";
              8'h26: glyph = "3#";
              8'h29: glyph = 16'h2020;
              8'h2A: glyph = "vV";
              8'h2B: glyph = "fF";
              8'h2C: glyph = "tT";
              8'h2D: glyph = "rR";
              8'h2E: glyph = "5%";
              8'h31: glyph = "nN";
              8'h32: glyph = "bB";
              8'h33: glyph = "hH";
              8'h34: glyph = "gG";
              8'h35: glyph = "yY";
              8'h36: glyph = "6^";
              8'h3A: glyph = "mM";
              8'h3B: glyph = "jJ";
              8'h3C: glyph = "uU";
              8'h3D: glyph = "7&";
              8'h3E: glyph = "8*";
              8'h41: glyph = ",<";
              8'h42: glyph = "kK";
              8'h43: glyph = "iI";
              8'h44: glyph = "oO";
              8'h45: glyph = "0)";
              8'h46: glyph = "9(";
              8'h49: glyph = ".>";
              8'h4A: glyph = "/?";
              8'h4B: glyph = "lL";
              8'h4C: glyph = ";:";
              8'h4D: glyph = "pP";
              8'h4E: glyph = "-_";
              8'h52: glyph = 16'h2722;
              8'h54: glyph = "[{";
              8'h55: glyph = "=+";
              8'h5A: glyph = 16'h0A0A;
              8'h5B: glyph = "]}";
              8'h5D: glyph = 16'h5C7C;
              8'h66: glyph = 16'h0808;
              8'h76: glyph = 16'h1B1B;
              default: glyph = 16'h0000;
            endcase
          end
          // letters follow shift xor caps, everything else shift alone
          alpha = (glyph[15:8] >= "a") && (glyph[15:8] <= "z");
          up = mods[ps2s2_pkg::MF_LSHIFT] | mods[ps2s2_pkg::MF_RSHIFT];
          if (alpha) up = up ^ caps;
          r.ascii_code = up ? glyph[6:0] : glyph[14:8];
          r.ascii_valid = (r.ascii_code != ps2s2_pkg::CHR_NONE);
        end
      end
    end
    r.shift = mods[ps2s2_pkg::MF_LSHIFT] | mods[ps2s2_pkg::MF_RSHIFT];
    r.ctrl = mods[ps2s2_pkg::MF_LCTRL] | mods[ps2s2_pkg::MF_RCTRL];
    r.alt = mods[ps2s2_pkg::MF_LALT] | mods[ps2s2_pkg::MF_RALT];
    r.caps = caps;
    return r;
  endfunction

  // Offer one request and record what it should give once taken
  task automatic send_byte(input logic [7:0] code, input logic aux, input logic fixed,
                           input key_result_t want);
    int          n;
    key_result_t pred;
    pick_wait(send_run, send_quiet, n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= code;
    from_aux <= aux;
    do @(posedge clk); while (!in_ready);
    pred = decode_byte(code, aux);
    expected_keys.push_back(fixed ? want : pred);
    if (!aux) key_bytes_fed++;
  endtask

  // Occasional ignored aux byte inside a sequence
  task automatic maybe_aux();
    if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, IDLE);
  endtask

  // Result checker
  always @(posedge clk) begin : take_result
    key_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_keys.size() == 0) begin
        report("result with no request waiting for it");
      end else begin
        want = expected_keys.pop_front();
        check_field("ascii_valid", 8'(ascii_valid), 8'(want.ascii_valid));
        check_field("ascii_code", 8'(ascii_code), 8'(want.ascii_code));
        check_field("event_valid", 8'(event_valid), 8'(want.event_valid));
        check_field("event_pressed", 8'(event_pressed), 8'(want.event_pressed));
        check_field("event_extended", 8'(event_extended), 8'(want.event_extended));
        check_field("event_code", event_code, want.event_code);
        check_field("shift_held", 8'(shift_held), 8'(want.shift));
        check_field("ctrl_active", 8'(ctrl_active), 8'(want.ctrl));
        check_field("alt_active", 8'(alt_active), 8'(want.alt));
        check_field("caps_on", 8'(caps_on), 8'(want.caps));
      end
    end
  end

  // Result side: random stalls, one long hold to back the queue up
  initial begin : receiver
    int          n;
    int          run;
    bit          quiet;
    int unsigned taken;
    run = 0;
    quiet = 1'b0;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      pick_wait(run, quiet, n);
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken == HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // Request side: directed rows, then random key sequences
  initial begin : sender
    int         pick;
    logic [7:0] code;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].code, DIRECTED[i].aux, DIRECTED[i].fixed, DIRECTED[i].want);

    while (key_bytes_fed < KEY_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // noise: any byte from either port
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, IDLE);
      end else if (pick < 14) begin
        // stray prefix, left for whatever comes next
        send_byte($urandom_range(0, 1) ? ps2s2_pkg::CODE_EXT : ps2s2_pkg::CODE_REL,
                  1'b0, 1'b0, IDLE);
      end else if (pick < 84) begin
        // plain make or break
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: code = TYPING_KEYS[$urandom_range(0, 17)];
          6:                code = MOD_KEYS[$urandom_range(0, 4)];
          default:          code = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 99) >= 60) begin
          send_byte(ps2s2_pkg::CODE_REL, 1'b0, 1'b0, IDLE);
          maybe_aux();
        end
        send_byte(code, 1'b0, 1'b0, IDLE);
      end else begin
        // extended make or break, prefixes in either order for a break
        code = ($urandom_range(0, 3) != 0) ? EXT_KEYS[$urandom_range(0, 5)]
                                           : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) begin
          send_byte(ps2s2_pkg::CODE_EXT, 1'b0, 1'b0, IDLE);
        end else if ($urandom_range(0, 1)) begin
          send_byte(ps2s2_pkg::CODE_EXT, 1'b0, 1'b0, IDLE);
          maybe_aux();
          send_byte(ps2s2_pkg::CODE_REL, 1'b0, 1'b0, IDLE);
        end else begin
          send_byte(ps2s2_pkg::CODE_REL, 1'b0, 1'b0, IDLE);
          maybe_aux();
          send_byte(ps2s2_pkg::CODE_EXT, 1'b0, 1'b0, IDLE);
        end
        maybe_aux();
        send_byte(code, 1'b0, 1'b0, IDLE);
      end
    end
    in_valid <= 1'b0;

    // drain, then wait for anything spurious
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_keys.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
